/* rtl/sigmoid_basis_expansion_defines.svh */
// ----------------------------------------------------------------------------
// Sigmoid basis expansion assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SIGMOID_BASIS_EXPANSION_DEFINES_SVH
`define SIGMOID_BASIS_EXPANSION_DEFINES_SVH

// Same-cycle implication.
`define SBE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SBE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sbe_pkg.sv */
// ----------------------------------------------------------------------------
// Sigmoid basis expansion package
// Sizes, register codes, shared types and the logistic table.
// ----------------------------------------------------------------------------
package sbe_pkg;

  localparam int NumBasis    = 8;
  localparam int NumFeatures = 16;
  localparam int IdxW        = (NumBasis > 1) ? $clog2(NumBasis) : 1;
  localparam int XW          = 16;
  localparam int KW          = 4;
  localparam int ValueW      = 16;
  localparam int ColW        = 7;
  localparam int TW          = 33;
  localparam int NumCenters  = 7;
  localparam int RegAddrW    = 3;
  localparam int PaddrW      = RegAddrW + 2;

  localparam logic [RegAddrW-1:0] RegInvScale   = 3'd0;
  localparam logic [15:0]         InvScaleReset = 16'd256;
  localparam logic [ValueW-1:0]   OneQ15        = 16'd32768;
  localparam logic signed [TW-1:0] SatLim       = 33'sd524288;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [KW-1:0] k;
  } sample_t;

  typedef struct packed {
    logic            valid;
    logic            bias;
    logic [TW-1:0]   t;
    logic [ColW-1:0] col;
    logic            last;
  } cell_res_t;

  // Logistic curve 1/(1+exp(-8 + i/2)) in Q1.15; entries past the end repeat the tail.
  function automatic logic [ValueW-1:0] logi(input logic [5:0] idx);
    logic [ValueW-1:0] v;
    case (idx)
      6'd0:    v = 16'd32757;
      6'd1:    v = 16'd32750;
      6'd2:    v = 16'd32738;
      6'd3:    v = 16'd32719;
      6'd4:    v = 16'd32687;
      6'd5:    v = 16'd32635;
      6'd6:    v = 16'd32549;
      6'd7:    v = 16'd32408;
      6'd8:    v = 16'd32179;
      6'd9:    v = 16'd31807;
      6'd10:   v = 16'd31214;
      6'd11:   v = 16'd30282;
      6'd12:   v = 16'd28862;
      6'd13:   v = 16'd26790;
      6'd14:   v = 16'd23955;
      6'd15:   v = 16'd20397;
      6'd16:   v = 16'd16384;
      6'd17:   v = 16'd12371;
      6'd18:   v = 16'd8813;
      6'd19:   v = 16'd5978;
      6'd20:   v = 16'd3906;
      6'd21:   v = 16'd2486;
      6'd22:   v = 16'd1554;
      6'd23:   v = 16'd961;
      6'd24:   v = 16'd589;
      6'd25:   v = 16'd360;
      6'd26:   v = 16'd219;
      6'd27:   v = 16'd133;
      6'd28:   v = 16'd81;
      6'd29:   v = 16'd49;
      6'd30:   v = 16'd30;
      6'd31:   v = 16'd18;
      default: v = 16'd11;
    endcase
    return v;
  endfunction

endpackage

/* rtl/sbe_cell.sv */
// ----------------------------------------------------------------------------
// Sigmoid basis cell
// Holds one sample, forms its scaled distance to this cell's
// center and hands the sample on to the next cell.
// ----------------------------------------------------------------------------
module sbe_cell import sbe_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            in_valid_i,
  input  sample_t         in_sample_i,
  input  logic [15:0]     center_i,
  input  logic [15:0]     inv_scale_i,
  input  logic [IdxW-1:0] cell_idx_i,
  output logic            out_valid_o,
  output sample_t         out_sample_o,
  output cell_res_t       res_o
);

  logic              valid_q;
  sample_t           smp_q;
  logic [TW-1:0]     t_q, t_d;
  logic [ColW-1:0]   col_q, col_d;
  logic signed [16:0] delta;
  logic signed [33:0] prod;
  logic [10:0]       col_full;

  assign delta = $signed({in_sample_i.x[XW-1], in_sample_i.x}) - $signed({center_i[15], center_i});
  assign prod  = delta * $signed({1'b0, inv_scale_i});
  assign t_d   = prod[TW-1:0];

  assign col_full = 11'(in_sample_i.k) * 11'(NumBasis) + 11'(cell_idx_i);
  assign col_d    = col_full[ColW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && in_valid_i) begin
      smp_q <= in_sample_i;
      t_q   <= t_d;
      col_q <= col_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_sample_o = smp_q;

  always_comb begin
    res_o.valid = valid_q;
    res_o.bias  = (cell_idx_i == '0);
    res_o.t     = t_q;
    res_o.col   = col_q;
    res_o.last  = (cell_idx_i == IdxW'(NumBasis - 1));
  end

endmodule

/* rtl/sbe_eval.sv */
// ----------------------------------------------------------------------------
// Sigmoid basis evaluator
// Picks the one live cell, saturates its argument, looks up the logistic
// segment (or takes 1.0 for the bias cell) and interpolates into the output register.
// ----------------------------------------------------------------------------
module sbe_eval import sbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  cell_res_t         res_i [NumBasis],
  output logic              out_valid_o,
  output logic [ValueW-1:0] basis_value_o,
  output logic [ColW-1:0]   column_index_o,
  output logic              last_of_run_o
);

  cell_res_t              sel;
  logic signed [TW-1:0]   tv, tsat;
  logic [20:0]            u;
  logic [5:0]             seg;
  logic [ValueW-1:0]      seg_hi, seg_lo, hi_d, step16;
  logic [11:0]            diff_d;

  logic                   a_valid_q;
  logic [ValueW-1:0]      a_hi_q;
  logic [11:0]            a_diff_q;
  logic [14:0]            a_fr_q;
  logic [ColW-1:0]        a_col_q;
  logic                   a_last_q;

  logic [27:0]            rnd;
  logic [ValueW-1:0]      val_d;

  logic                   valid_q;
  logic [ValueW-1:0]      val_q;
  logic [ColW-1:0]        col_q;
  logic                   last_q;

  // At most one cell is live, so an OR merge selects it.
  always_comb begin
    sel = '0;
    for (int j = 0; j < NumBasis; j++) begin
      if (res_i[j].valid) begin
        sel = sel | res_i[j];
      end
    end
  end

  always_comb begin
    tv = $signed(sel.t);
    if (tv > SatLim) begin
      tsat = SatLim;
    end else if (tv < -SatLim) begin
      tsat = -SatLim;
    end else begin
      tsat = tv;
    end
    u      = tsat[20:0] + SatLim[20:0];
    seg    = u[20:15];
    seg_hi = logi(seg);
    seg_lo = logi(seg + 6'd1);
    step16 = seg_hi - seg_lo;
    if (sel.bias) begin
      hi_d   = OneQ15;
      diff_d = '0;
    end else begin
      hi_d   = seg_hi;
      diff_d = step16[11:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      valid_q   <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= sel.valid;
      valid_q   <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_hi_q   <= hi_d;
      a_diff_q <= diff_d;
      a_fr_q   <= u[14:0];
      a_col_q  <= sel.col;
      a_last_q <= sel.last;
      val_q    <= val_d;
      col_q    <= a_col_q;
      last_q   <= a_last_q;
    end
  end

  // Interpolate down from the segment's upper point, rounded.
  assign rnd   = 28'(a_diff_q) * 28'(a_fr_q) + 28'd16384;
  assign val_d = a_hi_q - 16'(rnd[27:15]);

  assign out_valid_o    = valid_q;
  assign basis_value_o  = val_q;
  assign column_index_o = col_q;
  assign last_of_run_o  = last_q;

endmodule

/* rtl/sigmoid_basis_expansion.sv */
// ----------------------------------------------------------------------------
// Sigmoid basis expansion
// Expands one feature sample into a bias entry and logistic basis entries.
// ----------------------------------------------------------------------------
// Each request (a Q8.8 feature value with its feature index) yields NUM_BASIS
// results in column order on the result channel: first the bias 1.0, then one
// logistic entry per configured center, the final one flagged last_of_run. A
// sample with an index at or beyond NUM_FEATURES is taken and dropped. A sample
// walks one cell per cycle down a row of cells, unless stalled, and the single
// result channel carries one entry per cycle unless stalled, so the next
// request is taken while the previous sample sits in its last cell. The first
// result is registered in the head cell, the evaluator stage and its output
// register. Stall on the result channel freezes the whole row. Registers sit
// on an APB port at byte address 4*i: inv_scale, then center_one .. center_seven.
// ----------------------------------------------------------------------------
`include "sigmoid_basis_expansion_defines.svh"

module sigmoid_basis_expansion import sbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [XW-1:0]     feature_value_i,
  input  logic [KW-1:0]     feature_index_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ValueW-1:0] basis_value_o,
  output logic [ColW-1:0]   column_index_o,
  output logic              last_of_run_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0]         inv_scale_q;
  logic [15:0]         centers_q [1:NumCenters];
  logic [RegAddrW-1:0] reg_idx;
  logic                cfg_wr;

  logic                adv;
  logic                chain_busy;
  logic                accept;
  logic                in_ok;

  logic [NumBasis-1:0] cell_valid;
  logic [NumBasis-1:0] cin_valid;
  sample_t             cin_smp  [NumBasis];
  sample_t             cout_smp [NumBasis];
  logic [15:0]         ccenter  [NumBasis];
  cell_res_t           cres     [NumBasis];

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_scale_q <= InvScaleReset;
      for (int i = 1; i <= NumCenters; i++) begin
        centers_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      if (reg_idx == RegInvScale) begin
        inv_scale_q <= pwdata[15:0];
      end else begin
        centers_q[reg_idx] <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (reg_idx == RegInvScale) begin
      prdata = {16'b0, inv_scale_q};
    end else begin
      prdata = {16'b0, centers_q[reg_idx]};
    end
  end

  // Request side: the row holds one sample at a time.
  assign adv        = !out_valid_o || !out_stall_i;
  assign chain_busy = |cell_valid[NumBasis-2:0];
  assign in_stall_o = !(adv && !chain_busy);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_ok      = 32'(feature_index_i) < 32'(NumFeatures);

  for (genvar j = 0; j < NumBasis; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign cin_valid[j] = accept && in_ok;
      assign cin_smp[j]   = '{x: feature_value_i, k: feature_index_i};
      assign ccenter[j]   = '0;
    end else begin : g_body
      assign cin_valid[j] = cell_valid[j-1];
      assign cin_smp[j]   = cout_smp[j-1];
      assign ccenter[j]   = centers_q[j];
    end

    sbe_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .adv_i        (adv),
      .in_valid_i   (cin_valid[j]),
      .in_sample_i  (cin_smp[j]),
      .center_i     (ccenter[j]),
      .inv_scale_i  (inv_scale_q),
      .cell_idx_i   (IdxW'(j)),
      .out_valid_o  (cell_valid[j]),
      .out_sample_o (cout_smp[j]),
      .res_o        (cres[j])
    );
  end

  sbe_eval u_eval (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .res_i          (cres),
    .out_valid_o    (out_valid_o),
    .basis_value_o  (basis_value_o),
    .column_index_o (column_index_o),
    .last_of_run_o  (last_of_run_o)
  );

  `SBE_ASSERT_IMP(a_one_live_cell, 1'b1, $onehot0(cell_valid), "more than one live cell")
  `SBE_ASSERT_NXT(a_req_enters_row, accept && in_ok, cell_valid[0], "request did not enter row")
  `SBE_ASSERT_NXT(a_row_reaches_end, adv && cell_valid[NumBasis-2], cell_valid[NumBasis-1],
                  "sample lost before last cell")
  `SBE_ASSERT_IMP(a_value_range, out_valid_o, basis_value_o <= OneQ15, "basis value above one")

endmodule
